// File: rtl/grid_bucket_nearest_match_macros.svh
// Assertion macros used by the top level of the grid bucket match RTL.
`ifndef GRID_BUCKET_NEAREST_MATCH_MACROS_SVH
`define GRID_BUCKET_NEAREST_MATCH_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define GBNM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define GBNM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/gbnm_pkg.sv
// Shared types, constants and helpers of the grid bucket match block.
package gbnm_pkg;

  localparam int MAX_POINTS = 4096;
  localparam int PT_AW      = $clog2(MAX_POINTS);
  localparam int MAX_ZONES  = 1024;
  localparam int ZONE_AW    = $clog2(MAX_ZONES);
  localparam int GRID_SIDE  = 32;
  localparam int COORD_W    = $clog2(GRID_SIDE);
  localparam int DIM_W      = 6;
  localparam int POS_W      = 24;
  localparam int TAG_W      = 16;
  localparam int DIST_W     = 40;
  localparam int LINK_W     = PT_AW + 1;
  localparam int PT_W       = LINK_W + 2 * POS_W + TAG_W;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int CFG_IDX_W  = 3;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_QUERY  = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_BELOW = 2'd2
  } status_e;

  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ZONE_RECIP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ZONE_COLS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ZONE_ROWS  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_RAD = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ERR_RAD_SQ = 3'd6;

  // Classified word handed from the front end to the back end
  typedef struct packed {
    op_e                op;
    logic [POS_W-1:0]   pos_x;
    logic [POS_W-1:0]   pos_y;
    logic [TAG_W-1:0]   tag;
    logic               below;
    logic [COORD_W-1:0] lo_c;
    logic [COORD_W-1:0] hi_c;
    logic [COORD_W-1:0] lo_r;
    logic [COORD_W-1:0] hi_r;
  } cmd_t;

  // Back end status seen by the top level
  typedef struct packed {
    logic            sweeping;
    logic [PT_AW:0]  count;
  } back_stat_t;

  // Clamp a grid dimension to 1..GRID_SIDE
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] n);
    logic [DIM_W-1:0] r;
    r = n;
    if (n == '0) r = DIM_W'(1);
    else if (n > DIM_W'(GRID_SIDE)) r = DIM_W'(GRID_SIDE);
    return r;
  endfunction

endpackage

// File: rtl/grid_bucket_nearest_match.sv
// Top level of the grid bucket nearest match block.
//
// Input queue: drive a word on operation_i/pos_x_i/pos_y_i/point_tag_i with
// push high; it is taken at an edge where full is low. Result queue: a
// result sits on the result ports while empty is low and leaves on pop.
// Every word gives exactly one result, in order.
// Configuration: cfg_we_i writes cfg_wdata_i to register cfg_idx_i at once;
// write only while no word is in flight.
// The front end holds one word while it forms four window products on one
// multiplier, then hands it to a four-deep queue. The back end works one
// word at a time: an insert reads and writes the memories, a clear sweeps
// the bucket memory one zone per cycle, and a query reads each zone scanned
// and walks each stored point through the single read port of the point memory.
// After reset the back end sweeps the bucket memory; words
// are still taken into the queue meanwhile. If the receiver stalls, the
// result waits in the output register, the back end stops at its end, and
// the queue and front end fill before full rises.
`include "grid_bucket_nearest_match_macros.svh"

module grid_bucket_nearest_match (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   push,
  output logic                                   full,
  input  logic [1:0]                             operation_i,
  input  logic [gbnm_pkg::POS_W-1:0]             pos_x_i,
  input  logic [gbnm_pkg::POS_W-1:0]             pos_y_i,
  input  logic [gbnm_pkg::TAG_W-1:0]             point_tag_i,
  output logic                                   empty,
  input  logic                                   pop,
  output logic [1:0]                             status_o,
  output logic                                   matched_o,
  output logic [gbnm_pkg::TAG_W-1:0]             match_tag_o,
  output logic [gbnm_pkg::PT_AW-1:0]             match_slot_o,
  output logic [gbnm_pkg::DIST_W-1:0]            distance_sq_o,
  input  logic                                   cfg_we_i,
  input  logic [gbnm_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [gbnm_pkg::DIST_W-1:0]            cfg_wdata_i
);

  logic [gbnm_pkg::POS_W-1:0]  origin_x_q, origin_y_q, zone_recip_q, search_radius_q;
  logic [gbnm_pkg::DIM_W-1:0]  zone_cols_q, zone_rows_q, cols, rows;
  logic [gbnm_pkg::DIST_W-1:0] err_radius_sq_q;

  gbnm_pkg::cmd_t       f_cmd, q_cmd;
  logic                 f_push, q_full, q_empty, b_pop, out_valid;
  gbnm_pkg::back_stat_t b_stat;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q      <= '0;
      origin_y_q      <= '0;
      zone_recip_q    <= gbnm_pkg::POS_W'(65536);
      zone_cols_q     <= gbnm_pkg::DIM_W'(1);
      zone_rows_q     <= gbnm_pkg::DIM_W'(1);
      search_radius_q <= '0;
      err_radius_sq_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        gbnm_pkg::CFG_ORIGIN_X:   origin_x_q      <= cfg_wdata_i[gbnm_pkg::POS_W-1:0];
        gbnm_pkg::CFG_ORIGIN_Y:   origin_y_q      <= cfg_wdata_i[gbnm_pkg::POS_W-1:0];
        gbnm_pkg::CFG_ZONE_RECIP: zone_recip_q    <= cfg_wdata_i[gbnm_pkg::POS_W-1:0];
        gbnm_pkg::CFG_ZONE_COLS:  zone_cols_q     <= cfg_wdata_i[gbnm_pkg::DIM_W-1:0];
        gbnm_pkg::CFG_ZONE_ROWS:  zone_rows_q     <= cfg_wdata_i[gbnm_pkg::DIM_W-1:0];
        gbnm_pkg::CFG_SEARCH_RAD: search_radius_q <= cfg_wdata_i[gbnm_pkg::POS_W-1:0];
        gbnm_pkg::CFG_ERR_RAD_SQ: err_radius_sq_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Effective grid size
  assign cols = gbnm_pkg::eff_dim(zone_cols_q);
  assign rows = gbnm_pkg::eff_dim(zone_rows_q);

  gbnm_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push),
    .full_o          (full),
    .operation_i     (operation_i),
    .pos_x_i         (pos_x_i),
    .pos_y_i         (pos_y_i),
    .point_tag_i     (point_tag_i),
    .origin_x_i      (origin_x_q),
    .origin_y_i      (origin_y_q),
    .zone_recip_i    (zone_recip_q),
    .cols_i          (cols),
    .rows_i          (rows),
    .search_radius_i (search_radius_q),
    .cmd_o           (f_cmd),
    .cmd_push_o      (f_push),
    .cmd_full_i      (q_full)
  );

  gbnm_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .wdata_i (f_cmd),
    .full_o  (q_full),
    .pop_i   (b_pop),
    .rdata_o (q_cmd),
    .empty_o (q_empty)
  );

  gbnm_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (q_cmd),
    .cmd_empty_i     (q_empty),
    .cmd_pop_o       (b_pop),
    .cols_i          (cols),
    .err_radius_sq_i (err_radius_sq_q),
    .out_valid_o     (out_valid),
    .out_pop_i       (pop),
    .status_o        (status_o),
    .matched_o       (matched_o),
    .match_tag_o     (match_tag_o),
    .match_slot_o    (match_slot_o),
    .distance_sq_o   (distance_sq_o),
    .stat_o          (b_stat)
  );

  assign empty = !out_valid;

  `GBNM_ASSERT_NOW(a_count_bound, 1'b1,
      b_stat.count <= (gbnm_pkg::PT_AW+1)'(gbnm_pkg::MAX_POINTS), "point count overflow")
  `GBNM_ASSERT_NOW(a_match_in_radius, !empty && matched_o,
      distance_sq_o < err_radius_sq_q && status_o == gbnm_pkg::ST_OK, "match outside radius")
  `GBNM_ASSERT_NOW(a_reject_clean, !empty && status_o != gbnm_pkg::ST_OK,
      !matched_o && match_slot_o == '0, "rejected insert carries data")
  `GBNM_ASSERT_NOW(a_sweep_blocks_pop, b_stat.sweeping, !b_pop, "queue popped during sweep")

endmodule

// File: rtl/gbnm_ram.sv
// Generic single-port RAM with registered read.
module gbnm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write and read at one address
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/gbnm_front.sv
// Front end: accept a word, compute its zone window with one shared multiplier.
module gbnm_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push_i,
  output logic                                full_o,
  input  logic [1:0]                          operation_i,
  input  logic [gbnm_pkg::POS_W-1:0]          pos_x_i,
  input  logic [gbnm_pkg::POS_W-1:0]          pos_y_i,
  input  logic [gbnm_pkg::TAG_W-1:0]          point_tag_i,
  input  logic [gbnm_pkg::POS_W-1:0]          origin_x_i,
  input  logic [gbnm_pkg::POS_W-1:0]          origin_y_i,
  input  logic [gbnm_pkg::POS_W-1:0]          zone_recip_i,
  input  logic [gbnm_pkg::DIM_W-1:0]          cols_i,
  input  logic [gbnm_pkg::DIM_W-1:0]          rows_i,
  input  logic [gbnm_pkg::POS_W-1:0]          search_radius_i,
  output gbnm_pkg::cmd_t                      cmd_o,
  output logic                                cmd_push_o,
  input  logic                                cmd_full_i
);

  typedef enum logic [1:0] {F_IDLE, F_MUL, F_PUSH} fstate_e;

  localparam int VW = gbnm_pkg::POS_W + 3;
  localparam int PW = 2 * gbnm_pkg::POS_W + 1;

  fstate_e             state_q;
  logic [2:0]          cnt_q;
  gbnm_pkg::cmd_t      item_q;
  logic [PW-1:0]       prod_q;
  logic                neg_q;

  logic signed [VW-1:0] dxo, dyo, rr, v;
  logic [PW-1:0]        prod_d;
  logic [PW-1:0]        quot;
  logic [gbnm_pkg::DIM_W-1:0]   n;
  logic [gbnm_pkg::COORD_W-1:0] coord;

  // Offsets from the origin, widened by the window half-width on queries
  always_comb begin
    dxo = $signed({3'b000, item_q.pos_x}) - $signed({3'b000, origin_x_i});
    dyo = $signed({3'b000, item_q.pos_y}) - $signed({3'b000, origin_y_i});
    rr  = (item_q.op == gbnm_pkg::OP_QUERY) ? $signed({3'b000, search_radius_i}) : '0;
    case (cnt_q[1:0])
      2'd0:    v = dxo - rr;
      2'd1:    v = dxo + rr;
      2'd2:    v = dyo - rr;
      default: v = dyo + rr;
    endcase
    prod_d = PW'(v[gbnm_pkg::POS_W:0]) * PW'(zone_recip_i);
  end

  // Clamp the previous product to the grid
  always_comb begin
    n     = (cnt_q < 3'd3) ? cols_i : rows_i;
    quot  = prod_q >> gbnm_pkg::POS_W;
    if (neg_q) coord = '0;
    else if (quot >= PW'(n)) coord = gbnm_pkg::COORD_W'(n - 1'b1);
    else coord = quot[gbnm_pkg::COORD_W-1:0];
  end

  // Sequence: accept, four products, push
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      cnt_q   <= '0;
      neg_q   <= 1'b0;
    end else begin
      case (state_q)
        F_IDLE: begin
          if (push_i) begin
            item_q.op    <= gbnm_pkg::op_e'(operation_i);
            item_q.pos_x <= pos_x_i;
            item_q.pos_y <= pos_y_i;
            item_q.tag   <= point_tag_i;
            item_q.below <= (pos_x_i < origin_x_i) || (pos_y_i < origin_y_i);
            cnt_q        <= '0;
            state_q      <= F_MUL;
          end
        end
        F_MUL: begin
          case (cnt_q)
            3'd1:    item_q.lo_c <= coord;
            3'd2:    item_q.hi_c <= coord;
            3'd3:    item_q.lo_r <= coord;
            3'd4:    item_q.hi_r <= coord;
            default: ;
          endcase
          prod_q <= prod_d;
          neg_q  <= v[VW-1];
          cnt_q  <= cnt_q + 3'd1;
          if (cnt_q == 3'd4) state_q <= F_PUSH;
        end
        F_PUSH: begin
          if (!cmd_full_i) state_q <= F_IDLE;
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

  assign full_o     = (state_q != F_IDLE);
  assign cmd_push_o = (state_q == F_PUSH) && !cmd_full_i;
  assign cmd_o      = item_q;

endmodule

// File: rtl/gbnm_fifo.sv
// Short queue of classified words between front and back end.
module gbnm_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  gbnm_pkg::cmd_t wdata_i,
  output logic           full_o,
  input  logic           pop_i,
  output gbnm_pkg::cmd_t rdata_o,
  output logic           empty_o
);

  gbnm_pkg::cmd_t            mem_q [gbnm_pkg::FIFO_DEPTH];
  logic [gbnm_pkg::FIFO_AW:0] wp_q, rp_q;

  // Store on push
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q[gbnm_pkg::FIFO_AW-1:0]] <= wdata_i;
  end

  // Advance pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 1'b1;
      if (pop_i)  rp_q <= rp_q + 1'b1;
    end
  end

  assign empty_o = (wp_q == rp_q);
  assign full_o  = (wp_q[gbnm_pkg::FIFO_AW] != rp_q[gbnm_pkg::FIFO_AW]) &&
                   (wp_q[gbnm_pkg::FIFO_AW-1:0] == rp_q[gbnm_pkg::FIFO_AW-1:0]);
  assign rdata_o = mem_q[rp_q[gbnm_pkg::FIFO_AW-1:0]];

endmodule

// File: rtl/gbnm_back.sv
// Back end: bucket and point memories, insert, window scan, clear sweep.
module gbnm_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  gbnm_pkg::cmd_t                cmd_i,
  input  logic                          cmd_empty_i,
  output logic                          cmd_pop_o,
  input  logic [gbnm_pkg::DIM_W-1:0]    cols_i,
  input  logic [gbnm_pkg::DIST_W-1:0]   err_radius_sq_i,
  output logic                          out_valid_o,
  input  logic                          out_pop_i,
  output logic [1:0]                    status_o,
  output logic                          matched_o,
  output logic [gbnm_pkg::TAG_W-1:0]    match_tag_o,
  output logic [gbnm_pkg::PT_AW-1:0]    match_slot_o,
  output logic [gbnm_pkg::DIST_W-1:0]   distance_sq_o,
  output gbnm_pkg::back_stat_t          stat_o
);

  typedef enum logic [3:0] {
    S_SWEEP, S_IDLE, S_DISP, S_INS_RD, S_INS_WR, S_Q_ZONE, S_Q_HEAD,
    S_Q_PT, S_Q_CMP, S_Q_NEXTZ, S_EMIT
  } bstate_e;

  localparam int PAW = gbnm_pkg::PT_AW;
  localparam int ZAW = gbnm_pkg::ZONE_AW;
  localparam int CW  = gbnm_pkg::COORD_W;
  localparam int PSW = gbnm_pkg::POS_W;
  localparam int TW  = gbnm_pkg::TAG_W;
  localparam int DW  = gbnm_pkg::DIST_W;
  localparam int LW  = gbnm_pkg::LINK_W;
  localparam int SQW = 2 * PSW;

  bstate_e          state_q;
  gbnm_pkg::cmd_t   cmd_q;
  logic [ZAW-1:0]   sw_q;
  logic             clr_q;
  logic [PAW:0]     count_q;
  logic [CW-1:0]    i_q, j_q;
  logic [DW-1:0]    best_q;
  logic             found_q;
  logic [PAW-1:0]   best_slot_q, p_q;
  logic [TW-1:0]    best_tag_q, tag_q;
  logic [LW-1:0]    link_q;
  logic [SQW-1:0]   sqx_q, sqy_q;
  logic             out_valid_q;
  logic [1:0]       res_status_q;
  logic             res_matched_q;
  logic [TW-1:0]    res_tag_q;
  logic [PAW-1:0]   res_slot_q;
  logic [DW-1:0]    res_dist_q;

  logic             bk_we;
  logic [ZAW-1:0]   bk_addr, zaddr;
  logic [LW-1:0]    bk_wdata, bk_rdata;
  logic             pt_we;
  logic [PAW-1:0]   pt_addr;
  logic [gbnm_pkg::PT_W-1:0] pt_wdata, pt_rdata;
  logic [2*CW:0]    zmul;
  logic [PSW:0]     dxs, dys;
  logic [PSW-1:0]   adx, ady;
  logic [SQW:0]     dsum;

  // Zone address of the current row and column
  always_comb begin
    zmul  = (2*CW+1)'(i_q) * (2*CW+1)'(cols_i);
    zaddr = zmul[ZAW-1:0] + ZAW'(j_q);
  end

  // Memory port control
  always_comb begin
    bk_we    = (state_q == S_SWEEP) || (state_q == S_INS_WR);
    bk_addr  = (state_q == S_SWEEP) ? sw_q : zaddr;
    bk_wdata = (state_q == S_SWEEP) ? '0 : {1'b1, count_q[PAW-1:0]};
    pt_we    = (state_q == S_INS_WR);
    pt_wdata = {bk_rdata, cmd_q.pos_x, cmd_q.pos_y, cmd_q.tag};
    case (state_q)
      S_INS_WR: pt_addr = count_q[PAW-1:0];
      S_Q_HEAD: pt_addr = bk_rdata[PAW-1:0];
      default:  pt_addr = link_q[PAW-1:0];
    endcase
  end

  // Distance terms of the point just read
  always_comb begin
    dxs  = {1'b0, pt_rdata[PSW+PSW+TW-1 -: PSW]} - {1'b0, cmd_q.pos_x};
    dys  = {1'b0, pt_rdata[PSW+TW-1 -: PSW]} - {1'b0, cmd_q.pos_y};
    adx  = dxs[PSW] ? PSW'(-dxs) : dxs[PSW-1:0];
    ady  = dys[PSW] ? PSW'(-dys) : dys[PSW-1:0];
    dsum = (SQW+1)'(sqx_q) + (SQW+1)'(sqy_q);
  end

  gbnm_ram #(.Width(LW), .Depth(gbnm_pkg::MAX_ZONES)) u_bucket_ram (
    .clk_i   (clk_i),
    .we_i    (bk_we),
    .addr_i  (bk_addr),
    .wdata_i (bk_wdata),
    .rdata_o (bk_rdata)
  );

  gbnm_ram #(.Width(gbnm_pkg::PT_W), .Depth(gbnm_pkg::MAX_POINTS)) u_point_ram (
    .clk_i   (clk_i),
    .we_i    (pt_we),
    .addr_i  (pt_addr),
    .wdata_i (pt_wdata),
    .rdata_o (pt_rdata)
  );

  assign cmd_pop_o = (state_q == S_IDLE) && !cmd_empty_i;

  // Sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_SWEEP;
      sw_q        <= '0;
      clr_q       <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
    end else begin
      if (out_pop_i && out_valid_q) out_valid_q <= 1'b0;
      case (state_q)
        S_SWEEP: begin
          sw_q <= sw_q + 1'b1;
          if (sw_q == ZAW'(gbnm_pkg::MAX_ZONES - 1)) begin
            state_q <= clr_q ? S_EMIT : S_IDLE;
          end
        end
        S_IDLE: begin
          if (!cmd_empty_i) begin
            cmd_q   <= cmd_i;
            state_q <= S_DISP;
          end
        end
        S_DISP: begin
          i_q           <= cmd_q.lo_r;
          j_q           <= cmd_q.lo_c;
          best_q        <= err_radius_sq_i;
          found_q       <= 1'b0;
          res_status_q  <= gbnm_pkg::ST_OK;
          res_matched_q <= 1'b0;
          res_tag_q     <= '0;
          res_slot_q    <= '0;
          res_dist_q    <= '0;
          case (cmd_q.op)
            gbnm_pkg::OP_INSERT: begin
              if (cmd_q.below) begin
                res_status_q <= gbnm_pkg::ST_BELOW;
                state_q      <= S_EMIT;
              end else if (count_q[PAW]) begin
                res_status_q <= gbnm_pkg::ST_FULL;
                state_q      <= S_EMIT;
              end else begin
                state_q <= S_INS_RD;
              end
            end
            gbnm_pkg::OP_QUERY: state_q <= S_Q_ZONE;
            gbnm_pkg::OP_CLEAR: begin
              count_q <= '0;
              sw_q    <= '0;
              clr_q   <= 1'b1;
              state_q <= S_SWEEP;
            end
            default: state_q <= S_EMIT;
          endcase
        end
        S_INS_RD: state_q <= S_INS_WR;
        S_INS_WR: begin
          res_slot_q <= count_q[PAW-1:0];
          count_q    <= count_q + 1'b1;
          state_q    <= S_EMIT;
        end
        S_Q_ZONE: state_q <= S_Q_HEAD;
        S_Q_HEAD: begin
          p_q     <= bk_rdata[PAW-1:0];
          state_q <= bk_rdata[PAW] ? S_Q_PT : S_Q_NEXTZ;
        end
        S_Q_PT: begin
          sqx_q   <= adx * adx;
          sqy_q   <= ady * ady;
          link_q  <= pt_rdata[gbnm_pkg::PT_W-1 -: LW];
          tag_q   <= pt_rdata[TW-1:0];
          state_q <= S_Q_CMP;
        end
        S_Q_CMP: begin
          if (dsum < (SQW+1)'(best_q)) begin
            best_q      <= dsum[DW-1:0];
            best_slot_q <= p_q;
            best_tag_q  <= tag_q;
            found_q     <= 1'b1;
          end
          p_q     <= link_q[PAW-1:0];
          state_q <= link_q[PAW] ? S_Q_PT : S_Q_NEXTZ;
        end
        S_Q_NEXTZ: begin
          if (j_q == cmd_q.hi_c) begin
            j_q <= cmd_q.lo_c;
            i_q <= i_q + 1'b1;
            if (i_q == cmd_q.hi_r) begin
              res_matched_q <= found_q;
              res_tag_q     <= found_q ? best_tag_q : '0;
              res_slot_q    <= found_q ? best_slot_q : '0;
              res_dist_q    <= best_q;
              state_q       <= S_EMIT;
            end else begin
              state_q <= S_Q_ZONE;
            end
          end else begin
            j_q     <= j_q + 1'b1;
            state_q <= S_Q_ZONE;
          end
        end
        S_EMIT: begin
          clr_q <= 1'b0;
          if (!out_valid_q) begin
            out_valid_q   <= 1'b1;
            status_o      <= res_status_q;
            matched_o     <= res_matched_q;
            match_tag_o   <= res_tag_q;
            match_slot_o  <= res_slot_q;
            distance_sq_o <= res_dist_q;
            state_q       <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign stat_o.sweeping = (state_q == S_SWEEP);
  assign stat_o.count    = count_q;

endmodule
